>>> hw/rtl/bct_pkg.sv
`timescale 1ns / 1ps

package bct_pkg;

  // default sizing
  localparam int unsigned NODE_COUNT_DEF   = 1024;
  localparam int unsigned MAX_CODE_LEN_DEF = 16;
  localparam int unsigned SYMBOL_BITS_DEF  = 16;

  // fixed field widths of the channels
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned CODE_SEL_W = 4;
  localparam int unsigned LEN_IN_W   = 5;
  localparam int unsigned SYM_W      = 16;
  localparam int unsigned STATUS_W   = 2;

  // internal length and bit counter width, holds up to 63
  localparam int unsigned LEN_W = 6;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

>>> hw/rtl/bct_in_if.sv
`timescale 1ns / 1ps

interface bct_in_if;
  logic                             valid;
  logic                             ready;
  logic [bct_pkg::CMD_W-1:0]        command;
  logic [bct_pkg::CODE_W-1:0]       code_bits;
  logic [bct_pkg::LEN_IN_W-1:0]     code_length;
  logic [bct_pkg::SYM_W-1:0]        symbol_in;

  modport source (output valid, command, code_bits, code_length, symbol_in, input ready);
  modport sink   (input valid, command, code_bits, code_length, symbol_in, output ready);
endinterface

>>> hw/rtl/bct_out_if.sv
`timescale 1ns / 1ps

interface bct_out_if;
  logic                          valid;
  logic                          ready;
  logic [bct_pkg::STATUS_W-1:0]  status;
  logic [bct_pkg::SYM_W-1:0]     symbol_out;

  modport source (output valid, status, symbol_out, input ready);
  modport sink   (input valid, status, symbol_out, output ready);
endinterface

>>> hw/rtl/bct_ram.sv
`timescale 1ns / 1ps

module bct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/binary_code_trie_top.sv
`timescale 1ns / 1ps

// binary prefix-code trie over a node pool in one synchronous ram
//
// in_ch carries commands: insert code_bits/code_length with symbol_in, or look up
// code_bits/code_length. code_bits holds the first bit at position code_length-1.
// out_ch returns one result per command: status (ok, miss, pool full) and the
// symbol found on a successful lookup, zero otherwise.
//
// one command is walked at a time. the node ram is read for the root and then for
// each existing child the walk follows, the read data feeding the next read
// address directly. a command walks one step per bit from transfer, then does the
// final write or check and loads the result register; in_ch is ready again once
// the result is registered, and a lookup that misses early ends sooner. a
// finished result sits in the output register while the next command is
// already walking.
// if out_ch stalls with a result still held, the walk waits at its final step
// without touching the ram until the register frees.
// reset clears the root (through a valid flag, no sweep), sets the free pointer
// to node 1 and empties the output register; the block is ready next cycle.
module binary_code_trie_top #(
  parameter int unsigned NODE_COUNT   = bct_pkg::NODE_COUNT_DEF,
  parameter int unsigned MAX_CODE_LEN = bct_pkg::MAX_CODE_LEN_DEF,
  parameter int unsigned SYMBOL_BITS  = bct_pkg::SYMBOL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bct_in_if.sink    in_ch,
  bct_out_if.source out_ch
);

  localparam int unsigned IDX_W  = $clog2(NODE_COUNT);
  localparam int unsigned NF_W   = $clog2(NODE_COUNT + 1);
  localparam int unsigned NODE_W = 1 + SYMBOL_BITS + 2 * IDX_W;

  // one pool entry: word end flag, symbol, child for bit one, child for bit zero
  typedef struct packed {
    logic                   word_end;
    logic [SYMBOL_BITS-1:0] sym;
    logic [IDX_W-1:0]       kid1;
    logic [IDX_W-1:0]       kid0;
  } node_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t state;

  // command under way
  logic [bct_pkg::CMD_W-1:0]  cmd;
  logic [bct_pkg::CODE_W-1:0] bits;
  logic [bct_pkg::LEN_W-1:0]  len;
  logic [SYMBOL_BITS-1:0]     sym;

  // walk position
  logic [IDX_W-1:0]          cur;
  logic [bct_pkg::LEN_W-1:0] step;
  logic                      from_ram;   // current node comes from ram read data
  node_t                     node_reg;   // freshly allocated node, not yet in ram
  logic [NF_W-1:0]           next_free;
  logic                      root_valid;

  // output register
  logic                          out_valid;
  logic [bct_pkg::STATUS_W-1:0]  out_status;
  logic [bct_pkg::SYM_W-1:0]     out_symbol;

  // ram ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  node_t             ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [NODE_W-1:0] ram_rdata;

  // walk decode
  node_t                         node_cur;
  logic [bct_pkg::LEN_W-1:0]     bit_pos;
  logic                          bit_val;
  logic                          at_end;
  logic [IDX_W-1:0]              nxt;
  logic                          nxt_oob;
  logic                          pool_full;
  logic                          slot_free;
  logic                          in_xfer;
  logic [bct_pkg::LEN_W-1:0]     len_in;

  logic                          done;
  logic                          we_req;
  logic                          go_child;
  logic                          alloc;
  logic [bct_pkg::STATUS_W-1:0]  res_status;
  logic [bct_pkg::SYM_W-1:0]     res_symbol;

  bct_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready       = (state == S_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.symbol_out = out_symbol;
  assign slot_free         = !out_valid || out_ch.ready;

  // lengths above the maximum saturate
  assign len_in = (bct_pkg::LEN_W'(in_ch.code_length) > bct_pkg::LEN_W'(MAX_CODE_LEN))
                  ? bct_pkg::LEN_W'(MAX_CODE_LEN)
                  : bct_pkg::LEN_W'(in_ch.code_length);

  always_comb begin
    // root reads as cleared until it is first written
    if (from_ram) begin
      node_cur = (cur == '0 && !root_valid) ? '0 : node_t'(ram_rdata);
    end else begin
      node_cur = node_reg;
    end

    at_end    = (step == len);
    bit_pos   = len - step - bct_pkg::LEN_W'(1);
    // positions above the codeword field read as zero
    bit_val   = (bit_pos < bct_pkg::LEN_W'(bct_pkg::CODE_W))
                ? bits[bit_pos[bct_pkg::CODE_SEL_W-1:0]] : 1'b0;
    nxt       = bit_val ? node_cur.kid1 : node_cur.kid0;
    nxt_oob   = ({1'b0, nxt} >= (IDX_W + 1)'(NODE_COUNT));
    pool_full = (next_free >= NF_W'(NODE_COUNT));

    done       = 1'b0;
    we_req     = 1'b0;
    go_child   = 1'b0;
    alloc      = 1'b0;
    res_status = bct_pkg::ST_OK;
    res_symbol = '0;
    ram_waddr  = cur;
    ram_wdata  = node_cur;
    ram_re     = 1'b0;
    ram_raddr  = nxt;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      S_WALK: begin
        if (cmd == bct_pkg::CMD_LOOKUP) begin
          if (at_end) begin
            done = 1'b1;
            if (node_cur.word_end) begin
              res_symbol = bct_pkg::SYM_W'(node_cur.sym);
            end else begin
              res_status = bct_pkg::ST_MISS;
            end
          end else if (nxt == '0 || nxt_oob) begin
            done       = 1'b1;
            res_status = bct_pkg::ST_MISS;
          end else begin
            ram_re   = 1'b1;
            go_child = 1'b1;
          end
        end else begin
          if (at_end) begin
            done               = 1'b1;
            we_req             = 1'b1;
            ram_wdata.word_end = 1'b1;
            ram_wdata.sym      = sym;
          end else if (nxt != '0) begin
            ram_re   = 1'b1;
            go_child = 1'b1;
          end else if (pool_full) begin
            // a fresh node still has to land in ram as an empty node
            done       = 1'b1;
            res_status = bct_pkg::ST_FULL;
            we_req     = !from_ram;
          end else begin
            alloc  = 1'b1;
            we_req = 1'b1;
            if (bit_val) begin
              ram_wdata.kid1 = next_free[IDX_W-1:0];
            end else begin
              ram_wdata.kid0 = next_free[IDX_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase

    // the final step waits for a free output register
    ram_we = we_req && (!done || slot_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_free  <= NF_W'(1);
      root_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ram_we && ram_waddr == '0) begin
        root_valid <= 1'b1;
      end

      // a result loaded at this edge keeps the register full
      if (out_valid && out_ch.ready && !(done && slot_free)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state    <= S_WALK;
            cmd      <= in_ch.command;
            bits     <= in_ch.code_bits;
            len      <= len_in;
            sym      <= in_ch.symbol_in[SYMBOL_BITS-1:0];
            cur      <= '0;
            step     <= '0;
            from_ram <= 1'b1;
          end
        end
        S_WALK: begin
          if (done) begin
            if (slot_free) begin
              state      <= S_IDLE;
              out_valid  <= 1'b1;
              out_status <= res_status;
              out_symbol <= res_symbol;
            end
          end else if (go_child) begin
            cur      <= nxt;
            step     <= step + bct_pkg::LEN_W'(1);
            from_ram <= 1'b1;
          end else if (alloc) begin
            cur       <= next_free[IDX_W-1:0];
            step      <= step + bct_pkg::LEN_W'(1);
            from_ram  <= 1'b0;
            node_reg  <= '0;
            next_free <= next_free + NF_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
